[hdl/round_robin_task_ring_scheduler_unit_assert.svh]
// assertion macros for the task ring scheduler
`ifndef ROUND_ROBIN_TASK_RING_SCHEDULER_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TASK_RING_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RRTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrts check failed");

// next-cycle implication, checked out of reset
`define RRTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrts check failed");

`endif

[hdl/rrts_pkg.sv]
package rrts_pkg;

  // command codes
  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_LINK   = 3'd1;
  localparam logic [2:0] CMD_START  = 3'd2;
  localparam logic [2:0] CMD_YIELD  = 3'd3;
  localparam logic [2:0] CMD_QUAR   = 3'd4;
  localparam logic [2:0] CMD_TERM   = 3'd5;

  // error codes
  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_FULL    = 3'd1;
  localparam logic [2:0] ERR_NONE    = 3'd2;
  localparam logic [2:0] ERR_NOSTART = 3'd3;
  localparam logic [2:0] ERR_UNUSED  = 3'd4;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_RUN  = 2'd1,
    ST_QUAR = 2'd2,
    ST_TERM = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] task_req;
    logic [2:0] link_target;
  } in_item_t;

  typedef struct packed {
    logic [2:0] current_task;
    logic [2:0] previous_task;
    logic [2:0] created_task;
    logic       switched;
    logic [2:0] error_code;
  } out_item_t;

  // write request from the sequencer to the slot store
  typedef struct packed {
    logic       alloc;
    logic       st_we;
    logic [2:0] st_addr;
    status_t    st_data;
    logic       nx_we;
    logic [2:0] nx_addr;
    logic [2:0] nx_data;
  } mem_wr_t;

endpackage

[hdl/rrts_slot_store.sv]
module rrts_slot_store import rrts_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] st_rd_addr,
  input  logic [2:0] nx_rd_addr,
  input  mem_wr_t    wr,
  output status_t    st_rd_data,
  output logic [2:0] nx_rd_data,
  output logic       full,
  output logic [2:0] alloc_slot
);

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam int CNT_W = $clog2(NUM_TASKS + 1);
  localparam int EXT_W = IDX_W + 3;
  localparam int CMP_W = CNT_W + 3;

  status_t          st_mem [NUM_TASKS];
  logic [IDX_W-1:0] nx_mem [NUM_TASKS];

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  status_t          st_q;
  logic             used_q;
  logic [IDX_W-1:0] nx_q;

  logic [EXT_W-1:0] st_rd_ext, nx_rd_ext, st_wr_ext, nx_wr_ext, nx_dat_ext, nx_q_ext;
  logic [CMP_W-1:0] count_ext;
  logic [IDX_W-1:0] st_widx, nx_widx, nx_wdata;
  status_t          st_wdata;
  logic             st_wen, nx_wen;

  assign st_rd_ext  = EXT_W'(st_rd_addr);
  assign nx_rd_ext  = EXT_W'(nx_rd_addr);
  assign st_wr_ext  = EXT_W'(wr.st_addr);
  assign nx_wr_ext  = EXT_W'(wr.nx_addr);
  assign nx_dat_ext = EXT_W'(wr.nx_data);
  assign nx_q_ext   = EXT_W'(nx_q);
  assign count_ext  = CMP_W'(count_r);

  // a new slot is always the one at the fill count
  assign st_wen   = wr.alloc | wr.st_we;
  assign nx_wen   = wr.alloc | wr.nx_we;
  assign st_widx  = wr.alloc ? count_r[IDX_W-1:0] : st_wr_ext[IDX_W-1:0];
  assign st_wdata = wr.alloc ? ST_RUN : wr.st_data;
  assign nx_widx  = wr.alloc ? count_r[IDX_W-1:0] : nx_wr_ext[IDX_W-1:0];
  assign nx_wdata = wr.alloc ? count_r[IDX_W-1:0] : nx_dat_ext[IDX_W-1:0];

  assign count_nxt = wr.alloc ? count_r + 1'b1 : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_wen) begin
      st_mem[st_widx] <= st_wdata;
    end
    st_q   <= st_mem[st_rd_ext[IDX_W-1:0]];
    used_q <= (CMP_W'(st_rd_addr) < count_ext);
  end

  always_ff @(posedge clk) begin
    if (nx_wen) begin
      nx_mem[nx_widx] <= nx_wdata;
    end
    nx_q <= nx_mem[nx_rd_ext[IDX_W-1:0]];
  end

  // slots at or beyond the fill count were never handed out and read as free
  assign st_rd_data = used_q ? st_q : ST_FREE;
  assign nx_rd_data = nx_q_ext[2:0];
  assign full       = (count_r == CNT_W'(NUM_TASKS));
  assign alloc_slot = count_ext[2:0];

endmodule

[hdl/rrts_seq.sv]
module rrts_seq import rrts_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start_i,
  input  in_item_t   in_item,
  output logic       idle_o,
  output logic       res_valid_o,
  input  logic       res_take_i,
  output out_item_t  res_o,
  output logic [2:0] st_rd_addr,
  output logic [2:0] nx_rd_addr,
  input  status_t    st_rd_data,
  input  logic [2:0] nx_rd_data,
  input  logic       full_i,
  input  logic [2:0] alloc_slot_i,
  output mem_wr_t    wr
);

  localparam int N_W = $clog2(NUM_TASKS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_LINK = 5'b00100,
    S_WALK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  logic [2:0] req_r, req_nxt;
  logic [2:0] tgt_r, tgt_nxt;
  logic [2:0] running_r, running_nxt;
  logic       started_r, started_nxt;
  logic [2:0] cand_r, cand_nxt;
  logic [N_W-1:0] cnt_r, cnt_nxt;
  out_item_t  res_r, res_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    req_nxt     = req_r;
    tgt_nxt     = tgt_r;
    running_nxt = running_r;
    started_nxt = started_r;
    cand_nxt    = cand_r;
    cnt_nxt     = cnt_r;
    res_nxt     = res_r;
    wr          = '0;
    case (state_r)
      S_IDLE: begin
        if (start_i) begin
          cmd_nxt   = in_item.cmd;
          req_nxt   = in_item.task_req;
          tgt_nxt   = in_item.link_target;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        res_nxt              = '0;
        res_nxt.current_task = running_r;
        state_nxt            = S_DONE;
        case (cmd_r)
          CMD_CREATE: begin
            if (full_i) begin
              res_nxt.error_code = ERR_FULL;
            end else begin
              wr.alloc             = 1'b1;
              res_nxt.created_task = alloc_slot_i;
            end
          end
          CMD_LINK: begin
            if (st_rd_data == ST_FREE) begin
              res_nxt.error_code = ERR_UNUSED;
            end else begin
              state_nxt = S_LINK;
            end
          end
          CMD_START: begin
            if (st_rd_data == ST_FREE) begin
              res_nxt.error_code = ERR_UNUSED;
            end else begin
              running_nxt          = req_r;
              started_nxt          = 1'b1;
              res_nxt.current_task = req_r;
              res_nxt.switched     = 1'b1;
            end
          end
          CMD_YIELD: begin
            if (!started_r) begin
              res_nxt.error_code = ERR_NOSTART;
            end else begin
              cand_nxt  = nx_rd_data;
              cnt_nxt   = '0;
              state_nxt = S_WALK;
            end
          end
          CMD_QUAR: begin
            if (st_rd_data == ST_FREE) begin
              res_nxt.error_code = ERR_UNUSED;
            end else if (st_rd_data == ST_RUN) begin
              wr.st_we   = 1'b1;
              wr.st_addr = req_r;
              wr.st_data = ST_QUAR;
            end
          end
          CMD_TERM: begin
            if (st_rd_data == ST_FREE) begin
              res_nxt.error_code = ERR_UNUSED;
            end else begin
              wr.st_we   = 1'b1;
              wr.st_addr = req_r;
              wr.st_data = ST_TERM;
            end
          end
          default: begin
          end
        endcase
      end
      S_LINK: begin
        if (st_rd_data == ST_FREE) begin
          res_nxt.error_code = ERR_UNUSED;
        end else begin
          wr.nx_we   = 1'b1;
          wr.nx_addr = req_r;
          wr.nx_data = tgt_r;
        end
        state_nxt = S_DONE;
      end
      S_WALK: begin
        if (st_rd_data == ST_RUN) begin
          running_nxt           = cand_r;
          res_nxt.current_task  = cand_r;
          res_nxt.previous_task = running_r;
          res_nxt.switched      = 1'b1;
          state_nxt             = S_DONE;
        end else if (st_rd_data == ST_FREE) begin
          res_nxt.error_code = ERR_UNUSED;
          state_nxt          = S_DONE;
        end else if (cnt_r == N_W'(NUM_TASKS)) begin
          res_nxt.error_code = ERR_NONE;
          state_nxt          = S_DONE;
        end else begin
          cand_nxt = nx_rd_data;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // reads are issued in the state before the one that uses them
  always_comb begin
    if (state_r == S_IDLE) begin
      st_rd_addr = in_item.task_req;
      nx_rd_addr = running_r;
    end else if (state_r == S_CHK && cmd_r == CMD_LINK) begin
      st_rd_addr = tgt_r;
      nx_rd_addr = nx_rd_data;
    end else begin
      st_rd_addr = nx_rd_data;
      nx_rd_addr = nx_rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      running_r <= '0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      running_r <= running_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    req_r  <= req_nxt;
    tgt_r  <= tgt_nxt;
    cand_r <= cand_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

  assign idle_o      = (state_r == S_IDLE);
  assign res_valid_o = (state_r == S_DONE);
  assign res_o       = res_r;

endmodule

[hdl/round_robin_task_ring_scheduler_unit.sv]
// from transfer in, create, start, quarantine, terminate and unknown commands pass S_CHK,
// then S_DONE; link passes S_CHK, S_LINK, S_DONE; a yield S_CHK, then S_WALK over at most
// NUM_TASKS+1 slots, then S_DONE; one item at a time, the next taken once S_IDLE returns
// the yield walk visits one slot per cycle, paced by the registered read of the slot memories
// reset (synchronous, active low) clears control and the fill count; slot status at or
// above the fill count reads as free, so there is no clearing pass
`include "round_robin_task_ring_scheduler_unit_assert.svh"

module round_robin_task_ring_scheduler_unit import rrts_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // sequencer <-> slot store
  logic       seq_idle;
  logic       accept;
  logic       res_valid;
  logic       res_take;
  out_item_t  res;
  logic [2:0] st_rd_addr;
  logic [2:0] nx_rd_addr;
  status_t    st_rd_data;
  logic [2:0] nx_rd_data;
  logic       pool_full;
  logic [2:0] alloc_slot;
  mem_wr_t    mem_wr;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // terms for the checks at the end
  logic      out_prev_set;
  logic      out_switch_ok;

  // only one command in flight; a finished result can still sit in the
  // output register while the next command is taken
  assign in_stall = !seq_idle;
  assign accept   = in_valid && !in_stall;

  // result moves out once the output register is empty or being drained
  assign res_take      = res_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = res_take || (out_valid_r && out_stall);

  rrts_seq #(
    .NUM_TASKS (NUM_TASKS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (accept),
    .in_item      (in_data),
    .idle_o       (seq_idle),
    .res_valid_o  (res_valid),
    .res_take_i   (res_take),
    .res_o        (res),
    .st_rd_addr   (st_rd_addr),
    .nx_rd_addr   (nx_rd_addr),
    .st_rd_data   (st_rd_data),
    .nx_rd_data   (nx_rd_data),
    .full_i       (pool_full),
    .alloc_slot_i (alloc_slot),
    .wr           (mem_wr)
  );

  // status and link memories; writes only happen in the last step of a
  // command, so no read that the command still uses meets a write
  rrts_slot_store #(
    .NUM_TASKS (NUM_TASKS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .st_rd_addr (st_rd_addr),
    .nx_rd_addr (nx_rd_addr),
    .wr         (mem_wr),
    .st_rd_data (st_rd_data),
    .nx_rd_data (nx_rd_data),
    .full       (pool_full),
    .alloc_slot (alloc_slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_prev_set  = out_valid && (out_data.previous_task != 3'd0);
  assign out_switch_ok = out_data.switched && (out_data.error_code == ERR_OK);

  // a transfer in always leaves the block busy on the following cycle
  `RRTS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a result handed over is shown on the output next cycle
  `RRTS_ASSERT_NXT(a_take_loads_out, res_take, out_valid)
  // a previous task is only reported by a successful switch
  `RRTS_ASSERT_IMP(a_prev_needs_switch, out_prev_set, out_switch_ok)

endmodule
